// ===== src/sorted_keyframe_table_assert.svh =====
// Assertion macros for the sorted keyframe table
`ifndef SORTED_KEYFRAME_TABLE_ASSERT_SVH
`define SORTED_KEYFRAME_TABLE_ASSERT_SVH
// implication checked at every clock edge outside reset
`define SKT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("sorted keyframe table check failed");
// next-cycle implication
`define SKT_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("sorted keyframe table check failed");
`endif

// ===== src/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Types and command codes of the sorted keyframe table.
// ----------------------------------------------------------------------------
`default_nettype none
package skt_pkg;
	localparam int TIME_W = 32;
	localparam int TOL_W = 16;

	typedef enum logic [3:0] {
		CMD_INSERT   = 4'd0,
		CMD_FIND     = 4'd1,
		CMD_READ     = 4'd2,
		CMD_DEL_TIME = 4'd3,
		CMD_DEL_HDL  = 4'd4,
		CMD_DEL_BEF  = 4'd5,
		CMD_DEL_AFT  = 4'd6,
		CMD_CLEAR    = 4'd7,
		CMD_REBASE   = 4'd8
	} cmd_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_APPLY,
		S_OUT
	} state_t;

	// cell row operation applied in the apply cycle
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_WRITE,
		OP_SHIFT_UP,
		OP_SHIFT_DOWN,
		OP_DROP_FRONT,
		OP_REBASE
	} cell_op_t;
endpackage
`default_nettype wire

// ===== src/sorted_keyframe_table.sv =====
// Flow: an accepted item passes the eval, apply and output states in turn;
// delete before holds in apply until every dropped entry has moved the row.
// No new item is taken until the result item leaves.
// Reset: arst_n clears fill count, tolerance (to 1) and control; stores are
// undefined until written and never read beyond the fill count.
// ----------------------------------------------------------------------------
// sorted_keyframe_table
// Time-sorted table of keyframes held in a row of cells.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_keyframe_table_assert.svh"
module sorted_keyframe_table #(
	parameter int DEPTH = 64,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// command[3:0], time_key[35:4], handle[51:36], entry_index[57:52], zero pad
	input  wire logic [63:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status[1:0], found_index[7:2], found_handle[23:8], found_time[55:24],
	// entry_count[62:56], zero pad
	output logic [63:0]      m_tdata
);
	import skt_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

	state_t state_q, state_d;
	logic [15:0] tol_q;
	logic [CNT_W-1:0] fill_q;
	logic [3:0] cmd_q;
	logic [31:0] time_q;
	logic [HANDLE_BITS-1:0] hdl_q;
	logic [5:0] idx_q;
	logic [1:0] res_status_q;
	logic [5:0] res_index_q;
	logic [15:0] res_handle_q;
	logic [31:0] res_time_q;
	logic [6:0] res_count_q;

	logic [31:0] cell_time [DEPTH];
	logic [HANDLE_BITS-1:0] cell_hdl [DEPTH];
	logic [DEPTH-1:0] not_above, hdl_match, eq_vec, floor_vec;
	logic [DEPTH-1:0] le_vec, prev_vec, next_vec;

	// eval results registered for the apply cycle
	cell_op_t op_q;
	logic [IDX_W-1:0] sel_q;
	logic [CNT_W-1:0] drop_q;
	logic [31:0] base_q;
	logic drop_more;

	assign drop_more = (op_q == OP_DROP_FRONT) && (drop_q > CNT_W'(1));

	assign cfg_ready = (state_q == S_IDLE);
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = {1'b0, res_count_q, res_time_q, res_handle_q, res_index_q, res_status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tol_q <= 16'd1;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) tol_q <= cfg_data;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_EVAL;
			S_EVAL: state_d = S_APPLY;
			S_APPLY: if (!drop_more) state_d = S_OUT;
			S_OUT: if (m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= s_tdata[3:0];
			time_q <= s_tdata[35:4];
			hdl_q <= HANDLE_BITS'(s_tdata[51:36]);
			idx_q <= s_tdata[57:52];
		end
	end

	function automatic logic same_t(input logic [31:0] a, input logic [31:0] b,
			input logic [15:0] tol);
		logic [31:0] d;
		d = (a > b) ? a - b : b - a;
		return d < {16'd0, tol};
	endfunction

	// per-cell flags: equal within tolerance, floor entry, not above the key
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			le_vec[i] = (CNT_W'(i) < fill_q) && not_above[i];
			eq_vec[i] = (CNT_W'(i) < fill_q) && same_t(time_q, cell_time[i], tol_q);
			if (i == DEPTH - 1)
				floor_vec[i] = (CNT_W'(i) < fill_q) && time_q > cell_time[i];
			else
				floor_vec[i] = (CNT_W'(i) < fill_q) && time_q > cell_time[i] &&
					(CNT_W'(i + 1) == fill_q || time_q < cell_time[i+1]);
		end
	end

	// le_vec is a prefix of ones: mark the last cell in it and the one after
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (i == DEPTH - 1)
				prev_vec[i] = le_vec[i];
			else
				prev_vec[i] = le_vec[i] && !le_vec[i+1];
			if (i == 0)
				next_vec[i] = (CNT_W'(i) < fill_q) && !le_vec[i];
			else
				next_vec[i] = (CNT_W'(i) < fill_q) && !le_vec[i] && le_vec[i-1];
		end
	end

	// leading-one searches and a count of the sorted prefix
	logic [CNT_W-1:0] p_cnt;
	logic find_hit, hdl_hit;
	logic [IDX_W-1:0] find_pos, hdl_pos;
	always_comb begin
		p_cnt = '0;
		find_hit = 1'b0;
		hdl_hit = 1'b0;
		find_pos = '0;
		hdl_pos = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (CNT_W'(i) < fill_q && not_above[i] && p_cnt == '0) p_cnt = CNT_W'(i + 1);
			if (eq_vec[i] || floor_vec[i]) begin
				find_hit = 1'b1;
				find_pos = IDX_W'(i);
			end
			if (CNT_W'(i) < fill_q && hdl_match[i]) begin
				hdl_hit = 1'b1;
				hdl_pos = IDX_W'(i);
			end
		end
	end

	// one read port into the row, address chosen by the command
	logic [IDX_W-1:0] rd_pos;
	logic [31:0] rd_time;
	logic [HANDLE_BITS-1:0] rd_hdl;
	always_comb begin
		case (cmd_q)
			CMD_READ: rd_pos = IDX_W'(idx_q);
			CMD_DEL_HDL: rd_pos = hdl_pos;
			default: rd_pos = find_pos;
		endcase
	end
	assign rd_time = cell_time[rd_pos];
	assign rd_hdl = cell_hdl[rd_pos];

	logic [IDX_W-1:0] pm1;
	assign pm1 = IDX_W'(p_cnt - 1'b1);
	logic prev_eq, next_eq;
	assign prev_eq = |(eq_vec & prev_vec);
	assign next_eq = |(eq_vec & next_vec);

	// eval: decide cell op, result fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			op_q <= OP_HOLD;
		end else if (state_q == S_EVAL) begin
			op_q <= OP_HOLD;
			res_status_q <= ST_OK;
			res_index_q <= '0;
			res_handle_q <= '0;
			res_time_q <= '0;
			sel_q <= '0;
			drop_q <= '0;
			base_q <= cell_time[0];
			case (cmd_q)
				CMD_INSERT: begin
					res_handle_q <= 16'(hdl_q);
					res_time_q <= time_q;
					if (prev_eq) begin
						op_q <= OP_WRITE; sel_q <= pm1; res_index_q <= 6'(pm1);
					end else if (next_eq) begin
						op_q <= OP_WRITE; sel_q <= IDX_W'(p_cnt);
						res_index_q <= 6'(p_cnt);
					end else if (fill_q == CNT_W'(DEPTH)) begin
						res_status_q <= ST_FULL; res_handle_q <= '0; res_time_q <= '0;
					end else begin
						op_q <= OP_SHIFT_UP; sel_q <= IDX_W'(p_cnt);
						res_index_q <= 6'(p_cnt); fill_q <= fill_q + 1'b1;
					end
				end
				CMD_FIND, CMD_DEL_TIME: begin
					if (!find_hit) res_status_q <= ST_NOT_FOUND;
					else begin
						res_index_q <= 6'(find_pos);
						res_handle_q <= 16'(rd_hdl);
						res_time_q <= rd_time;
						if (cmd_q == CMD_DEL_TIME) begin
							op_q <= OP_SHIFT_DOWN; sel_q <= find_pos;
							fill_q <= fill_q - 1'b1;
						end
					end
				end
				CMD_READ: begin
					if (CMP_W'(idx_q) >= CMP_W'(fill_q))
						res_status_q <= ST_NOT_FOUND;
					else begin
						res_index_q <= idx_q;
						res_handle_q <= 16'(rd_hdl);
						res_time_q <= rd_time;
					end
				end
				CMD_DEL_HDL: begin
					if (!hdl_hit) res_status_q <= ST_NOT_FOUND;
					else begin
						res_index_q <= 6'(hdl_pos);
						res_handle_q <= 16'(rd_hdl);
						res_time_q <= rd_time;
						op_q <= OP_SHIFT_DOWN; sel_q <= hdl_pos;
						fill_q <= fill_q - 1'b1;
					end
				end
				CMD_DEL_BEF: begin
					if (p_cnt >= CNT_W'(2)) begin
						op_q <= OP_DROP_FRONT; drop_q <= p_cnt - 1'b1;
						fill_q <= fill_q - (p_cnt - 1'b1);
					end
				end
				CMD_DEL_AFT: fill_q <= p_cnt;
				CMD_CLEAR: fill_q <= '0;
				CMD_REBASE: if (fill_q != '0) op_q <= OP_REBASE;
				default: ;
			endcase
		end else if (state_q == S_APPLY && drop_more) begin
			drop_q <= drop_q - 1'b1;
		end else begin
			op_q <= OP_HOLD;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_APPLY) res_count_q <= 7'(fill_q);
	end

	generate
		for (genvar g = 0; g < DEPTH; g++) begin : g_cell
			logic [31:0] bt, at;
			logic [HANDLE_BITS-1:0] bh, ah;
			if (g == 0) begin : g_lo
				assign bt = '0; assign bh = '0;
			end else begin : g_mid
				assign bt = cell_time[g-1]; assign bh = cell_hdl[g-1];
			end
			if (g == DEPTH - 1) begin : g_hi
				assign at = cell_time[g]; assign ah = cell_hdl[g];
			end else begin : g_nhi
				assign at = cell_time[g+1]; assign ah = cell_hdl[g+1];
			end
			skt_cell #(.HANDLE_BITS(HANDLE_BITS), .IDX_W(IDX_W)) u_cell (
				.clk(clk), .op(state_q == S_APPLY ? op_q : OP_HOLD),
				.my_index(IDX_W'(g)), .sel_index(sel_q),
				.cmd_time(time_q),
				.cmd_handle(hdl_q), .base_time(base_q),
				.below_time(bt), .below_handle(bh),
				.above_time(at), .above_handle(ah),
				.time_q(cell_time[g]), .handle_q(cell_hdl[g]),
				.not_above(not_above[g]), .hdl_match(hdl_match[g]));
		end
	endgenerate

	`SKT_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= CNT_W'(DEPTH))
	`SKT_ASSERT_NEXT(a_accept_eval, clk, arst_n, s_tvalid && s_tready, state_q == S_EVAL)
	`SKT_ASSERT_IMP(a_hs_excl, clk, arst_n, m_tvalid, !s_tready)
endmodule
`default_nettype wire

// ===== src/skt_cell.sv =====
// ----------------------------------------------------------------------------
// skt_cell
// One table slot: compares its key and handle with the command, takes the command's
// or its neighbor's entry when written or shifted, and subtracts the base on rebase.
// ----------------------------------------------------------------------------
`default_nettype none
module skt_cell #(
	parameter int HANDLE_BITS = 16,
	parameter int IDX_W = 6
) (
	input  wire logic                     clk,
	input  wire skt_pkg::cell_op_t        op,
	input  wire logic [IDX_W-1:0]         my_index,
	input  wire logic [IDX_W-1:0]         sel_index,
	input  wire logic [31:0]              cmd_time,
	input  wire logic [HANDLE_BITS-1:0]   cmd_handle,
	input  wire logic [31:0]              base_time,
	input  wire logic [31:0]              below_time,
	input  wire logic [HANDLE_BITS-1:0]   below_handle,
	input  wire logic [31:0]              above_time,
	input  wire logic [HANDLE_BITS-1:0]   above_handle,
	output logic [31:0]                   time_q,
	output logic [HANDLE_BITS-1:0]        handle_q,
	output logic                          not_above,
	output logic                          hdl_match
);
	import skt_pkg::*;

	assign not_above = time_q <= cmd_time;
	assign hdl_match = handle_q == cmd_handle;

	always_ff @(posedge clk) begin
		case (op)
			OP_WRITE: begin
				if (my_index == sel_index) begin
					time_q <= cmd_time;
					handle_q <= cmd_handle;
				end
			end
			OP_SHIFT_UP: begin
				if (my_index == sel_index) begin
					time_q <= cmd_time;
					handle_q <= cmd_handle;
				end else if (my_index > sel_index) begin
					time_q <= below_time;
					handle_q <= below_handle;
				end
			end
			OP_SHIFT_DOWN: begin
				if (my_index >= sel_index) begin
					time_q <= above_time;
					handle_q <= above_handle;
				end
			end
			// whole row moves down one slot per cycle
			OP_DROP_FRONT: begin
				time_q <= above_time;
				handle_q <= above_handle;
			end
			OP_REBASE: time_q <= time_q - base_time;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== test/sorted_keyframe_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_keyframe_table_tb
// Drives random and directed table commands through the stream port, models
// the sorted table alongside, and checks every result item field by field.
// ----------------------------------------------------------------------------
module sorted_keyframe_table_tb;
	import skt_pkg::*;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  index;
		logic [15:0] hdl;
		logic [31:0] tkey;
		logic [6:0]  count;
	} table_result_t;

	typedef struct {
		logic        is_cfg;
		logic [15:0] tol;
		logic [3:0]  cmd;
		logic [31:0] tkey;
		logic [15:0] hdl;
		logic [5:0]  idx;
	} table_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [15:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic [63:0] s_tdata = '0;
	logic m_tready = 1'b0;
	wire cfg_ready, s_tready, m_tvalid;
	wire [63:0] m_tdata;

	sorted_keyframe_table uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #1 clk = ~clk;

	// model table
	logic [31:0] mdl_time [DEPTH];
	logic [15:0] mdl_hdl [DEPTH];
	int mdl_fill = 0;
	logic [15:0] mdl_tol = 16'd1;

	table_item_t pending_items[$];
	table_result_t expected_results[$];
	int errors = 0;
	int cycles = 0;
	logic sink_hold = 1'b0;
	int drv_gap = 0;
	int mon_gap = 0;
	logic in_taken = 1'b0;
	logic cfg_taken = 1'b0;

	function automatic logic near(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = (a > b) ? a - b : b - a;
		return d < {16'd0, mdl_tol};
	endfunction

	function automatic int not_above(logic [31:0] t);
		int p;
		p = 0;
		while (p < mdl_fill && mdl_time[p] <= t) p++;
		return p;
	endfunction

	function automatic int floor_match(logic [31:0] t);
		for (int i = 0; i < mdl_fill; i++) begin
			if (near(t, mdl_time[i])) return i;
			if (t > mdl_time[i] && (i + 1 == mdl_fill || t < mdl_time[i + 1])) return i;
		end
		return -1;
	endfunction

	function automatic void drop_entry(int p);
		for (int i = p; i + 1 < mdl_fill; i++) begin
			mdl_time[i] = mdl_time[i + 1];
			mdl_hdl[i] = mdl_hdl[i + 1];
		end
		mdl_fill--;
	endfunction

	function automatic table_result_t apply_command(table_item_t it);
		table_result_t r;
		int p, f, drop;
		logic [31:0] base;
		r = '0;
		case (it.cmd)
			CMD_INSERT: begin
				p = not_above(it.tkey);
				if (p > 0 && near(it.tkey, mdl_time[p - 1])) begin
					p--;
					mdl_time[p] = it.tkey;
					mdl_hdl[p] = it.hdl;
				end else if (p < mdl_fill && near(it.tkey, mdl_time[p])) begin
					mdl_time[p] = it.tkey;
					mdl_hdl[p] = it.hdl;
				end else if (mdl_fill >= DEPTH) begin
					r.status = ST_FULL;
					p = -1;
				end else begin
					for (int i = mdl_fill; i > p; i--) begin
						mdl_time[i] = mdl_time[i - 1];
						mdl_hdl[i] = mdl_hdl[i - 1];
					end
					mdl_time[p] = it.tkey;
					mdl_hdl[p] = it.hdl;
					mdl_fill++;
				end
				if (p >= 0) begin
					r.index = p[5:0];
					r.hdl = it.hdl;
					r.tkey = it.tkey;
				end
			end
			CMD_FIND, CMD_DEL_TIME: begin
				f = floor_match(it.tkey);
				if (f < 0) r.status = ST_NOT_FOUND;
				else begin
					r.index = f[5:0];
					r.hdl = mdl_hdl[f];
					r.tkey = mdl_time[f];
					if (it.cmd == CMD_DEL_TIME) drop_entry(f);
				end
			end
			CMD_READ: begin
				if (int'(it.idx) >= mdl_fill) r.status = ST_NOT_FOUND;
				else begin
					r.index = it.idx;
					r.hdl = mdl_hdl[it.idx];
					r.tkey = mdl_time[it.idx];
				end
			end
			CMD_DEL_HDL: begin
				f = -1;
				for (int i = 0; i < mdl_fill; i++)
					if (f < 0 && mdl_hdl[i] == it.hdl) f = i;
				if (f < 0) r.status = ST_NOT_FOUND;
				else begin
					r.index = f[5:0];
					r.hdl = mdl_hdl[f];
					r.tkey = mdl_time[f];
					drop_entry(f);
				end
			end
			CMD_DEL_BEF: begin
				p = not_above(it.tkey);
				if (p >= 2) begin
					drop = p - 1;
					for (int i = 0; i + drop < mdl_fill; i++) begin
						mdl_time[i] = mdl_time[i + drop];
						mdl_hdl[i] = mdl_hdl[i + drop];
					end
					mdl_fill -= drop;
				end
			end
			CMD_DEL_AFT: mdl_fill = not_above(it.tkey);
			CMD_CLEAR: mdl_fill = 0;
			CMD_REBASE: begin
				if (mdl_fill > 0) begin
					base = mdl_time[0];
					for (int i = 0; i < mdl_fill; i++) mdl_time[i] -= base;
				end
			end
			default: ;
		endcase
		r.count = mdl_fill[6:0];
		return r;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	// times near existing entries so tolerance matches actually happen
	function automatic logic [31:0] pick_time();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'd0;
			2: return 32'hFFFF_FFFF;
			default: return {16'd0, 8'd0, 8'($urandom_range(0, 255))} << $urandom_range(0, 8);
		endcase
	endfunction

	function automatic void add_cmd(logic [3:0] c, logic [31:0] t, logic [15:0] h, logic [5:0] i);
		table_item_t it;
		it.is_cfg = 1'b0;
		it.tol = '0;
		it.cmd = c;
		it.tkey = t;
		it.hdl = h;
		it.idx = i;
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic void add_cfg(logic [15:0] v);
		table_item_t it;
		it = '{default: '0};
		it.is_cfg = 1'b1;
		it.tol = v;
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic void add_random(int n, int fill_bias);
		logic [3:0] c;
		int k;
		for (int j = 0; j < n; j++) begin
			k = $urandom_range(0, 99);
			if (k < fill_bias) c = CMD_INSERT;
			else if (k < 95) c = 4'($urandom_range(1, 8));
			else c = 4'($urandom_range(9, 15));
			if (c == CMD_CLEAR && $urandom_range(0, 3) != 0) c = CMD_FIND;
			add_cmd(c, pick_time(), 16'($urandom_range(0, 40)) ^
				($urandom_range(0, 7) == 0 ? 16'($urandom()) : 16'd0),
				6'($urandom_range(0, 63)));
		end
	endfunction

	// driver: commands and register writes, writes only when nothing is in flight
	always @(negedge clk) begin
		table_item_t it;
		if (arst_n) begin
			if ((s_tvalid || cfg_valid) && !(in_taken || cfg_taken)) begin
				// item still waiting for the block
			end else if (drv_gap > 0) begin
				s_tvalid <= 1'b0;
				cfg_valid <= 1'b0;
				drv_gap <= drv_gap - 1;
			end else if (pending_items.size() > 0 &&
					(!pending_items[0].is_cfg || expected_results.size() == 0)) begin
				it = pending_items.pop_front();
				drv_gap <= gap_len();
				if (it.is_cfg) begin
					cfg_data <= it.tol;
					cfg_valid <= 1'b1;
					s_tvalid <= 1'b0;
				end else begin
					s_tdata <= {6'd0, it.idx, it.hdl, it.tkey, it.cmd};
					s_tvalid <= 1'b1;
					cfg_valid <= 1'b0;
				end
			end else begin
				s_tvalid <= 1'b0;
				cfg_valid <= 1'b0;
			end
		end
	end

	// monitor: tracks accepted items for the model and checks result items
	always @(posedge clk) begin
		table_result_t got, want;
		table_item_t it;
		cycles <= cycles + 1;
		in_taken <= arst_n && s_tvalid && s_tready;
		cfg_taken <= arst_n && cfg_valid && cfg_ready;
		if (arst_n && cfg_valid && cfg_ready) mdl_tol = cfg_data;
		if (arst_n && s_tvalid && s_tready) begin
			it = '{default: '0};
			it.cmd = s_tdata[3:0];
			it.tkey = s_tdata[35:4];
			it.hdl = s_tdata[51:36];
			it.idx = s_tdata[57:52];
			expected_results.insert(expected_results.size(), apply_command(it));
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[1:0], m_tdata[7:2], m_tdata[23:8], m_tdata[55:24], m_tdata[62:56]};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected item %h", $time, got);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status)
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				if (got.index !== want.index)
					$display("%0t: index exp %0d got %0d", $time, want.index, got.index);
				if (got.hdl !== want.hdl)
					$display("%0t: handle exp %h got %h", $time, want.hdl, got.hdl);
				if (got.tkey !== want.tkey)
					$display("%0t: time exp %h got %h", $time, want.tkey, got.tkey);
				if (got.count !== want.count)
					$display("%0t: count exp %0d got %0d", $time, want.count, got.count);
				if (got !== want) errors++;
			end
		end
	end

	// sink readiness, with one long hold-off
	always @(negedge clk) begin
		if (sink_hold) m_tready <= 1'b0;
		else if (mon_gap > 0) begin
			m_tready <= 1'b0;
			mon_gap <= mon_gap - 1;
		end else if (m_tready && m_tvalid && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			mon_gap <= gap_len();
		end else m_tready <= 1'b1;
	end

	initial begin
		int hold_cycles;
		hold_cycles = 0;
		@(posedge clk);
		forever begin
			@(posedge clk);
			if (cycles == 3000) sink_hold <= 1'b1;
			if (sink_hold) begin
				hold_cycles++;
				if (hold_cycles == 300) sink_hold <= 1'b0;
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		// directed part
		add_cmd(CMD_FIND, 32'd5, 16'd0, 6'd0);
		add_cmd(CMD_REBASE, 32'd0, 16'd0, 6'd0);
		add_cmd(CMD_INSERT, 32'd100, 16'hFFFF, 6'd0);
		add_cmd(CMD_INSERT, 32'd0, 16'd1, 6'd0);
		add_cmd(CMD_INSERT, 32'hFFFF_FFFF, 16'd2, 6'd0);
		add_cmd(CMD_INSERT, 32'd100, 16'd3, 6'd0);
		add_cmd(CMD_FIND, 32'd50, 16'd0, 6'd0);
		add_cmd(CMD_READ, 32'd0, 16'd0, 6'd63);
		add_cmd(CMD_READ, 32'd0, 16'd0, 6'd2);
		add_cmd(CMD_DEL_HDL, 32'd0, 16'd3, 6'd0);
		add_cmd(CMD_DEL_HDL, 32'd0, 16'h7777, 6'd0);
		add_cmd(CMD_DEL_TIME, 32'd1, 16'd0, 6'd0);
		add_cmd(CMD_INSERT, 32'd200, 16'd4, 6'd0);
		add_cmd(CMD_INSERT, 32'd300, 16'd5, 6'd0);
		add_cmd(CMD_DEL_BEF, 32'd250, 16'd0, 6'd0);
		add_cmd(CMD_REBASE, 32'd0, 16'd0, 6'd0);
		add_cmd(CMD_DEL_AFT, 32'd50, 16'd0, 6'd0);
		add_cmd(4'd15, 32'hFFFF_FFFF, 16'hFFFF, 6'd63);
		add_cmd(CMD_CLEAR, 32'd0, 16'd0, 6'd0);
		add_cmd(CMD_DEL_TIME, 32'd9, 16'd0, 6'd0);
		add_cfg(16'hFFFF);
		add_random(150, 80);   // mostly inserts
		add_random(300, 40);
		add_cfg(16'd1);
		add_random(400, 55);
		add_cfg(16'd200);
		add_random(300, 45);
		add_cfg(16'($urandom_range(1, 65535)));
		add_random(300, 50);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (pending_items.size() > 0 || expected_results.size() > 0 ||
				s_tvalid || cfg_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
